// ===== rtl/imu_serial_frame_parser_core_defines.svh =====
// Assertion macros shared by the frame parser checker.
// Depends on nothing; include by bare file name.
`ifndef IMU_SERIAL_FRAME_PARSER_CORE_DEFINES_SVH
`define IMU_SERIAL_FRAME_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define ISPF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ISPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ispf_pkg.sv =====
// Shared types and constants of the sensor frame parser.
// Depends on nothing; imported by every parser module.
`default_nettype none

package ispf_pkg;

    localparam int HEADER_BYTES = 4;

    // Result status codes
    localparam logic [1:0] STATUS_DATA     = 2'd0;
    localparam logic [1:0] STATUS_HEADER   = 2'd1;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd2;
    localparam logic [1:0] STATUS_FAIL     = 2'd3;

    typedef enum logic [1:0] {
        CFG_DEVICE_ADDRESS = 2'd0,
        CFG_READ_OPCODE    = 2'd1,
        CFG_REGISTER_LIMIT = 2'd2,
        CFG_FAILURE_BUDGET = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        VERDICT_ADVANCE,
        VERDICT_DISCARD,
        VERDICT_GOOD
    } verdict_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DISCARD,
        ST_FAIL,
        ST_READ,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic take_byte;
        logic step;
        logic read_payload;
        logic emit_discard;
        logic emit_fail;
        logic emit_data;
    } dp_cmd_t;

    typedef struct packed {
        logic     byte_taken;
        verdict_t verdict;
        logic     fail_pending;
        logic     out_free;
        logic     data_last;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/ispf_byte_if.sv =====
// Valid/ready channel carrying one received link byte.
// Depends on nothing.
`default_nettype none

interface ispf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/ispf_result_if.sv =====
// Valid/ready channel carrying one parser result.
// Depends on nothing.
`default_nettype none

interface ispf_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [5:0] start_register;
    logic [5:0] byte_index;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output status, output start_register, output byte_index,
                    output data_byte, output last, input ready);
    modport sink   (input valid, input status, input start_register, input byte_index,
                    input data_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/ispf_ctrl.sv =====
// Sequencing state machine of the frame parser.
// Depends on ispf_pkg; drives commands into ispf_datapath.
`default_nettype none

module ispf_ctrl
    import ispf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.take_byte = 1'b1;
                if (status.byte_taken)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.step = 1'b1;
                case (status.verdict)
                    VERDICT_DISCARD: state_next = ST_DISCARD;
                    VERDICT_GOOD:    state_next = ST_READ;
                    default:         state_next = ST_IDLE;
                endcase
            end
            ST_DISCARD:
            begin
                if (status.out_free)
                begin
                    cmd.emit_discard = 1'b1;
                    state_next = status.fail_pending ? ST_FAIL : ST_IDLE;
                end
            end
            ST_FAIL:
            begin
                if (status.out_free)
                begin
                    cmd.emit_fail = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_READ:
            begin
                cmd.read_payload = 1'b1;
                state_next       = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_data = 1'b1;
                    state_next    = status.data_last ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ispf_datapath.sv =====
// Frame parser datapath: config registers, frame state, payload memory, result register.
// Depends on ispf_pkg, ispf_byte_if and ispf_result_if; steered by ispf_ctrl.
`default_nettype none

module ispf_datapath
    import ispf_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  wire logic [1:0] wr_index,
    input  wire logic [7:0] wr_data,
    ispf_byte_if.sink       rx,
    ispf_result_if.source   result,
    input  wire dp_cmd_t    cmd,
    output dp_status_t      status
);

    localparam int AW = $clog2(MAX_PAYLOAD);

    logic [7:0] device_address_reg;
    logic [7:0] read_opcode_reg;
    logic [6:0] register_limit_reg;
    logic [7:0] failure_budget_reg;

    logic [7:0] byte_reg;
    logic [6:0] position_reg;
    logic [5:0] frame_base_reg;
    logic [5:0] length_reg;
    logic [7:0] sum_reg;
    logic [8:0] count_reg;
    logic [1:0] discard_status_reg;
    logic       fail_pending_reg;
    logic [5:0] rd_idx_reg;
    logic [7:0] rdata_reg;

    logic       out_valid_reg;
    logic [1:0] out_status_reg;
    logic [5:0] out_start_reg;
    logic [5:0] out_index_reg;
    logic [7:0] out_data_reg;
    logic       out_last_reg;

    logic [7:0] payload_mem [MAX_PAYLOAD];

    logic [6:0] lim;
    logic [8:0] start_plus;
    logic [6:0] check_pos;
    logic [6:0] slot;
    logic [6:0] amount;
    logic [1:0] bad_status;
    logic [8:0] count_sum;
    logic       fail_now;
    logic       store_en;
    logic       data_last;
    logic       out_free;
    logic       out_load;
    verdict_t   verdict;

    // Effective limit: anything above the payload depth acts as the depth.
    assign lim        = (register_limit_reg > 7'(MAX_PAYLOAD)) ? 7'(MAX_PAYLOAD)
                                                               : register_limit_reg;
    assign start_plus = {3'b000, frame_base_reg} + {1'b0, byte_reg};
    assign check_pos  = {1'b0, length_reg} + 7'(HEADER_BYTES);
    assign slot       = position_reg - 7'(HEADER_BYTES);

    always_comb
    begin
        verdict    = VERDICT_ADVANCE;
        amount     = 7'd0;
        bad_status = STATUS_HEADER;
        case (position_reg)
            7'd0:
            begin
                if (byte_reg != device_address_reg)
                begin
                    verdict = VERDICT_DISCARD;
                    amount  = 7'd1;
                end
            end
            7'd1:
            begin
                if (byte_reg != read_opcode_reg)
                begin
                    verdict = VERDICT_DISCARD;
                    amount  = 7'd2;
                end
            end
            7'd2:
            begin
                if (byte_reg >= {1'b0, lim})
                begin
                    verdict = VERDICT_DISCARD;
                    amount  = 7'd3;
                end
            end
            7'd3:
            begin
                if (start_plus >= {2'b00, lim})
                begin
                    verdict = VERDICT_DISCARD;
                    amount  = 7'd4;
                end
            end
            default:
            begin
                if (position_reg == check_pos)
                begin
                    if (byte_reg != sum_reg)
                    begin
                        verdict    = VERDICT_DISCARD;
                        amount     = position_reg;
                        bad_status = STATUS_CHECKSUM;
                    end
                    else
                    begin
                        verdict = VERDICT_GOOD;
                    end
                end
            end
        endcase
    end

    assign count_sum = count_reg + {2'b00, amount};
    assign fail_now  = count_sum >= {1'b0, failure_budget_reg};
    assign store_en  = cmd.step && (verdict == VERDICT_ADVANCE)
                       && (position_reg >= 7'(HEADER_BYTES));
    assign data_last = (length_reg == 6'd0) || (rd_idx_reg == length_reg - 6'd1);
    assign out_free  = !out_valid_reg || result.ready;
    assign out_load  = cmd.emit_discard || cmd.emit_fail || cmd.emit_data;

    assign rx.ready = cmd.take_byte;

    assign status.byte_taken   = rx.valid && cmd.take_byte;
    assign status.verdict      = verdict;
    assign status.fail_pending = fail_pending_reg;
    assign status.out_free     = out_free;
    assign status.data_last    = data_last;

    assign result.valid          = out_valid_reg;
    assign result.status         = out_status_reg;
    assign result.start_register = out_start_reg;
    assign result.byte_index     = out_index_reg;
    assign result.data_byte      = out_data_reg;
    assign result.last           = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= 8'd164;
            read_opcode_reg    <= 8'd3;
            register_limit_reg <= 7'd64;
            failure_budget_reg <= 8'd48;
            position_reg       <= '0;
            frame_base_reg     <= '0;
            length_reg         <= '0;
            sum_reg            <= '0;
            count_reg          <= '0;
            discard_status_reg <= STATUS_HEADER;
            fail_pending_reg   <= 1'b0;
            rd_idx_reg         <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (wr_index)
                    CFG_DEVICE_ADDRESS: device_address_reg <= wr_data;
                    CFG_READ_OPCODE:    read_opcode_reg    <= wr_data;
                    CFG_REGISTER_LIMIT: register_limit_reg <= wr_data[6:0];
                    CFG_FAILURE_BUDGET: failure_budget_reg <= wr_data;
                    default: ;
                endcase
            end

            if (cmd.step)
            begin
                case (verdict)
                    VERDICT_DISCARD:
                    begin
                        position_reg       <= '0;
                        frame_base_reg     <= '0;
                        length_reg         <= '0;
                        sum_reg            <= '0;
                        count_reg          <= fail_now ? 9'd0 : count_sum;
                        discard_status_reg <= bad_status;
                        fail_pending_reg   <= fail_now;
                    end
                    VERDICT_GOOD:
                    begin
                        // hold start and length for the run, drop the failure count
                        count_reg  <= '0;
                        rd_idx_reg <= '0;
                    end
                    default:
                    begin
                        sum_reg      <= sum_reg + byte_reg;
                        position_reg <= position_reg + 7'd1;
                        if (position_reg == 7'd2)
                        begin
                            frame_base_reg <= byte_reg[5:0];
                        end
                        if (position_reg == 7'd3)
                        begin
                            length_reg <= byte_reg[5:0];
                        end
                    end
                endcase
            end

            if (cmd.emit_data)
            begin
                if (data_last)
                begin
                    position_reg   <= '0;
                    frame_base_reg <= '0;
                    length_reg     <= '0;
                    sum_reg        <= '0;
                end
                else
                begin
                    rd_idx_reg <= rd_idx_reg + 6'd1;
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers and memory carry no reset.
    always_ff @(posedge clk)
    begin
        if (status.byte_taken)
        begin
            byte_reg <= rx.rx_byte;
        end
        if (store_en)
        begin
            payload_mem[slot[AW-1:0]] <= byte_reg;
        end
        if (cmd.read_payload)
        begin
            rdata_reg <= payload_mem[rd_idx_reg[AW-1:0]];
        end
        if (cmd.emit_discard)
        begin
            out_status_reg <= discard_status_reg;
            out_start_reg  <= '0;
            out_index_reg  <= '0;
            out_data_reg   <= '0;
            out_last_reg   <= !fail_pending_reg;
        end
        else if (cmd.emit_fail)
        begin
            out_status_reg <= STATUS_FAIL;
            out_start_reg  <= '0;
            out_index_reg  <= '0;
            out_data_reg   <= '0;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.emit_data)
        begin
            out_status_reg <= STATUS_DATA;
            out_start_reg  <= frame_base_reg;
            out_index_reg  <= rd_idx_reg;
            out_data_reg   <= (length_reg == 6'd0) ? 8'd0 : rdata_reg;
            out_last_reg   <= data_last;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/imu_serial_frame_parser_core.sv =====
// Top level of the sensor reply frame parser.
// Depends on ispf_pkg, ispf_byte_if, ispf_result_if, ispf_ctrl and ispf_datapath.
//
// Usage:
//   rx carries one received link byte per transfer. result carries parser results:
//   status 0 data bytes of a good frame (one empty result for a zero-length frame),
//   status 1 header reject, status 2 checksum error, status 3 failure budget reached.
//   last marks the final result caused by one byte.
//   wr_en/wr_index/wr_data write device_address (0), read_opcode (1), register_limit (2)
//   and failure_budget (3); write only while the parser is idle.
// Sequencing:
//   One byte at a time. A byte that only advances the frame is accepted, then evaluated,
//   before ready rises again. A rejected byte then loads its results in turn (reject,
//   then fail when the budget is hit). A closing checksum byte of a good frame then
//   emits each payload byte in turn, or one empty result for an empty frame: each byte is
//   read from the payload memory with one registered read port, then loaded into the
//   result register. The sequencer state machine sets this order.
// Reset:
//   Asynchronous, active low; restores the register defaults, clears frame state and
//   the failure count. The payload memory is not cleared and needs no pass.
// Stalls:
//   A finished result waits in the one-entry result register; the next byte is still
//   taken once the pending result is loaded there. Further results hold until it drains.
`default_nettype none

module imu_serial_frame_parser_core
    import ispf_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  wire logic [1:0] wr_index,
    input  wire logic [7:0] wr_data,
    ispf_byte_if.sink       rx,
    ispf_result_if.source   result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer: decides when to take a byte, evaluate it and emit results.
    ispf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // Frame state, payload memory and the result register.
    ispf_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .rx       (rx),
        .result   (result),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

`default_nettype wire

// ===== rtl/ispf_checker.sv =====
// Port-level checks of the frame parser, bound to the top level.
// Depends on ispf_pkg and imu_serial_frame_parser_core_defines.svh.
`default_nettype none

`include "imu_serial_frame_parser_core_defines.svh"

module ispf_checker
    import ispf_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [1:0] res_status,
    input wire logic [5:0] res_start_register,
    input wire logic [5:0] res_byte_index,
    input wire logic [7:0] res_data_byte,
    input wire logic       res_last
);

    // A stalled result holds.
    `ISPF_ASSERT_NEXT(a_result_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_status) && $stable(res_data_byte) && $stable(res_last), "stalled result changed")

    // Status-only results carry zero fields.
    `ISPF_ASSERT_IMPLY(a_status_zero, clk, rst_n, res_valid && (res_status != STATUS_DATA), (res_start_register == 6'd0) && (res_byte_index == 6'd0) && (res_data_byte == 8'd0), "status result with nonzero fields")

    // A fail result always closes the run.
    `ISPF_ASSERT_IMPLY(a_fail_last, clk, rst_n, res_valid && (res_status == STATUS_FAIL), res_last, "fail result without last")

    // A discard that is not last is followed at once by a fail result.
    `ISPF_ASSERT_NEXT(a_discard_then_fail, clk, rst_n, res_valid && res_ready && !res_last && ((res_status == STATUS_HEADER) || (res_status == STATUS_CHECKSUM)), res_valid && (res_status == STATUS_FAIL), "missing fail after discard")

endmodule

bind imu_serial_frame_parser_core ispf_checker u_ispf_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .res_valid          (result.valid),
    .res_ready          (result.ready),
    .res_status         (result.status),
    .res_start_register (result.start_register),
    .res_byte_index     (result.byte_index),
    .res_data_byte      (result.data_byte),
    .res_last           (result.last)
);

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for imu_serial_frame_parser_core: feeds link bytes, predicts every parser
// result in step with each byte transfer and checks results field by field.
// Depends on ispf_pkg, ispf_byte_if, ispf_result_if and the parser RTL.
`default_nettype none

module tb;
    import ispf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAYLOAD_DEPTH   = 64;
    localparam int WATCHDOG_CYCLES = 3000;
    localparam int SETTLE_CYCLES   = 12;
    localparam int TAIL_CYCLES     = 20;

    // Register values after reset
    localparam logic [7:0] RESET_ADDRESS = 8'd164;
    localparam logic [7:0] RESET_OPCODE  = 8'd3;
    localparam logic [6:0] RESET_LIMIT   = 7'd64;
    localparam logic [7:0] RESET_BUDGET  = 8'd48;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] start_register;
        logic [5:0] byte_index;
        logic [7:0] data_byte;
        logic       last;
    } parser_result_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       wr_en;
    logic [1:0] wr_index;
    logic [7:0] wr_data;

    ispf_byte_if   rx_link ();
    ispf_result_if result_link ();

    imu_serial_frame_parser_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .rx       (rx_link),
        .result   (result_link)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Deframer state mirrored from the parser's behavior
    // ------------------------------------------------------------------
    logic [7:0] cfg_address;
    logic [7:0] cfg_opcode;
    logic [6:0] cfg_limit;
    logic [7:0] cfg_budget;

    logic [7:0] payload_mem [PAYLOAD_DEPTH];
    logic [6:0] frame_pos;
    logic [5:0] frame_start;
    logic [5:0] frame_len;
    logic [7:0] frame_sum;
    logic [8:0] fail_tally;

    parser_result_t parser_results_due [$];

    // Run statistics
    int bytes_sent;
    int results_checked;
    int mismatches;
    int frames_good;
    int header_rejects;
    int checksum_errors;
    int budget_fails;

    // Idling controls
    bit sender_gaps;
    bit sink_gaps;
    int hold_req;
    int hold_left;
    int stall_left;
    int idle_cycles;

    function automatic int usable_limit();
        // A limit above the payload depth acts as the depth itself
        return (int'(cfg_limit) > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : int'(cfg_limit);
    endfunction

    function automatic void await_result(logic [1:0] st, logic [5:0] start_val,
                                         logic [5:0] idx, logic [7:0] data, logic lst);
        parser_result_t r;
        r.status         = st;
        r.start_register = start_val;
        r.byte_index     = idx;
        r.data_byte      = data;
        r.last           = lst;
        parser_results_due.push_back(r);
    endfunction

    function automatic void clear_frame();
        frame_pos   = '0;
        frame_start = '0;
        frame_len   = '0;
        frame_sum   = '0;
    endfunction

    // Drop the partial frame, charge the failure count, and raise a fail once the
    // budget is reached (a budget of zero fails on every discard).
    function automatic void discard_frame(logic [1:0] st, int amount);
        fail_tally = fail_tally + 9'(amount);
        clear_frame();
        if (st == STATUS_HEADER)
            header_rejects++;
        else
            checksum_errors++;
        if (fail_tally >= {1'b0, cfg_budget})
        begin
            await_result(st, '0, '0, '0, 1'b0);
            await_result(STATUS_FAIL, '0, '0, '0, 1'b1);
            fail_tally = '0;
            budget_fails++;
        end
        else
        begin
            await_result(st, '0, '0, '0, 1'b1);
        end
    endfunction

    // Advance the deframer by one received byte and queue the results it causes
    function automatic void deframe_byte(logic [7:0] b);
        int lim;
        lim = usable_limit();
        case (frame_pos)
            7'd0:
            begin
                if (b != cfg_address)
                begin
                    discard_frame(STATUS_HEADER, 1);
                    return;
                end
            end
            7'd1:
            begin
                if (b != cfg_opcode)
                begin
                    discard_frame(STATUS_HEADER, 2);
                    return;
                end
            end
            7'd2:
            begin
                if (int'(b) >= lim)
                begin
                    discard_frame(STATUS_HEADER, 3);
                    return;
                end
                frame_start = b[5:0];
            end
            7'd3:
            begin
                if (int'(frame_start) + int'(b) >= lim)
                begin
                    discard_frame(STATUS_HEADER, 4);
                    return;
                end
                frame_len = b[5:0];
            end
            default:
            begin
                if (int'(frame_pos) == int'(frame_len) + HEADER_BYTES)
                begin
                    if (b != frame_sum)
                    begin
                        discard_frame(STATUS_CHECKSUM, int'(frame_pos));
                        return;
                    end
                    // Good frame: an empty frame still reports one result
                    if (frame_len == 0)
                        await_result(STATUS_DATA, frame_start, '0, '0, 1'b1);
                    else
                        for (int i = 0; i < int'(frame_len); i++)
                            await_result(STATUS_DATA, frame_start, 6'(i), payload_mem[i],
                                         i == int'(frame_len) - 1);
                    clear_frame();
                    fail_tally = '0;
                    frames_good++;
                    return;
                end
                payload_mem[int'(frame_pos) - HEADER_BYTES] = b;
            end
        endcase
        frame_sum = frame_sum + b;
        frame_pos = frame_pos + 7'd1;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting and result checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(string what);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // Check each result transfer against the oldest queued prediction
    always @(posedge clk)
    begin : result_check
        parser_result_t got;
        parser_result_t want;
        if (rst_n === 1'b1 && result_link.valid === 1'b1 && result_link.ready === 1'b1)
        begin
            got.status         = result_link.status;
            got.start_register = result_link.start_register;
            got.byte_index     = result_link.byte_index;
            got.data_byte      = result_link.data_byte;
            got.last           = result_link.last;
            results_checked++;
            if (parser_results_due.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result status=%0d idx=%0d data=%02h",
                                        got.status, got.byte_index, got.data_byte));
            end
            else
            begin
                want = parser_results_due.pop_front();
                if (got.status !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d",
                                            got.status, want.status));
                if (got.start_register !== want.start_register)
                    flag_mismatch($sformatf("start_register %0d, want %0d",
                                            got.start_register, want.start_register));
                if (got.byte_index !== want.byte_index)
                    flag_mismatch($sformatf("byte_index %0d, want %0d",
                                            got.byte_index, want.byte_index));
                if (got.data_byte !== want.data_byte)
                    flag_mismatch($sformatf("data_byte %02h, want %02h",
                                            got.data_byte, want.data_byte));
                if (got.last !== want.last)
                    flag_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stall bursts plus a long hold on request.
    // The hold is counted here so the sender keeps offering bytes meanwhile.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_link.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_link.ready <= 1'b0;
        end
        else if (sink_gaps && $urandom_range(0, 9) == 0)
        begin
            // Stall burst of random length, this one included
            stall_left = $urandom_range(0, 11);
            result_link.ready <= 1'b0;
        end
        else
        begin
            result_link.ready <= 1'b1;
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((rx_link.valid === 1'b1 && rx_link.ready === 1'b1) ||
            (result_link.valid === 1'b1 && result_link.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("[%0t] watchdog: no transfer for %0d cycles, %0d results pending",
                     $realtime, WATCHDOG_CYCLES, parser_results_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one byte, wait for its transfer, then maybe idle the link for a burst
    task automatic send_byte(logic [7:0] b);
        int gap;
        @(negedge clk);
        rx_link.valid   <= 1'b1;
        rx_link.rx_byte <= b;
        do
            @(posedge clk);
        while (rx_link.ready !== 1'b1);
        deframe_byte(b);
        bytes_sent++;
        if (sender_gaps && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            rx_link.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Send a whole frame with random payload; corrupt the checksum on request
    task automatic send_frame(int start_sel, int len, bit bad_sum);
        logic [7:0] frame_bytes [$];
        logic [7:0] sum;
        frame_bytes.push_back(cfg_address);
        frame_bytes.push_back(cfg_opcode);
        frame_bytes.push_back(8'(start_sel));
        frame_bytes.push_back(8'(len));
        repeat (len) frame_bytes.push_back(8'($urandom));
        sum = '0;
        foreach (frame_bytes[i]) sum = sum + frame_bytes[i];
        if (bad_sum)
            sum = sum + 8'($urandom_range(1, 255));
        frame_bytes.push_back(sum);
        foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
    endtask

    // Hold the sender idle until every predicted result has been transferred
    task automatic pause_until_drained();
        @(negedge clk);
        rx_link.valid <= 1'b0;
        while (parser_results_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_register(cfg_index_t idx, logic [7:0] value);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(negedge clk);
        wr_en    <= 1'b0;
        case (idx)
            CFG_DEVICE_ADDRESS: cfg_address = value;
            CFG_READ_OPCODE:    cfg_opcode  = value;
            CFG_REGISTER_LIMIT: cfg_limit   = value[6:0];
            CFG_FAILURE_BUDGET: cfg_budget  = value;
            default: ;
        endcase
    endtask

    // Write all four registers once the parser has gone idle. A byte that only
    // advances the frame causes no result, so let its evaluation settle first.
    task automatic apply_settings(logic [7:0] address, logic [7:0] opcode,
                                  logic [7:0] limit, logic [7:0] budget);
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_register(CFG_DEVICE_ADDRESS, address);
        write_register(CFG_READ_OPCODE, opcode);
        write_register(CFG_REGISTER_LIMIT, limit);
        write_register(CFG_FAILURE_BUDGET, budget);
    endtask

    // Random traffic: mostly well-formed frames with random content, some broken
    // headers and some raw noise, until n more bytes have been transferred.
    task automatic run_traffic(int n);
        int stop;
        int pick;
        int lim;
        int st;
        int room;
        int len;
        int bad_pos;
        stop = bytes_sent + n;
        lim  = usable_limit();
        while (bytes_sent < stop)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 88)
            begin
                // Break off any partial frame left by noise so the next frame lines up
                while (frame_pos != 0)
                begin
                    case (frame_pos)
                        7'd1:    send_byte(~cfg_opcode);
                        7'd2,
                        7'd3:    send_byte(8'hFF);
                        default:
                            if (int'(frame_pos) == int'(frame_len) + HEADER_BYTES)
                                send_byte(frame_sum + 8'd1);
                            else
                                send_byte(8'($urandom));
                    endcase
                end
            end
            if (pick < 70 && lim > 0)
            begin
                st   = $urandom_range(0, lim - 1);
                room = lim - 1 - st;
                // Keep most frames short; now and then use the full room
                if ($urandom_range(0, 11) == 0)
                    len = $urandom_range(0, room);
                else
                    len = $urandom_range(0, (room < 6) ? room : 6);
                send_frame(st, len, $urandom_range(0, 9) == 0);
            end
            else if (pick < 88)
            begin
                // Broken header: valid prefix, then a bad byte at a random position
                bad_pos = $urandom_range(0, (lim == 0) ? 2 : 3);
                if (bad_pos == 0)
                begin
                    send_byte(cfg_address + 8'($urandom_range(1, 255)));
                end
                else
                begin
                    send_byte(cfg_address);
                    if (bad_pos == 1)
                    begin
                        send_byte(cfg_opcode ^ 8'($urandom_range(1, 255)));
                    end
                    else
                    begin
                        send_byte(cfg_opcode);
                        if (bad_pos == 2)
                        begin
                            send_byte(8'($urandom_range(lim, 255)));
                        end
                        else
                        begin
                            st = $urandom_range(0, lim - 1);
                            send_byte(8'(st));
                            send_byte(8'($urandom_range(lim - st, 255)));
                        end
                    end
                end
            end
            else
            begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset defaults: good frame, checksum error, and a reject at each header byte
    task automatic test_header_checks();
        send_frame(0, 1, 1'b0);
        send_frame(0, 0, 1'b1);
        send_byte(8'h00);
        send_byte(cfg_address);
        send_byte(8'hFF);
        send_byte(cfg_address);
        send_byte(cfg_opcode);
        send_byte(8'hFF);
        send_byte(cfg_address);
        send_byte(cfg_opcode);
        send_byte(8'd63);
        send_byte(8'd1);
    endtask

    // Register extremes: zero limit with zero budget, then an oversized limit
    task automatic test_register_extremes();
        apply_settings(8'h00, 8'hFF, 8'h00, 8'h00);
        // Every start register is rejected, and every discard raises a fail
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        apply_settings(8'hFF, 8'h00, 8'hFF, 8'hFF);
        // Limit clamps to the payload depth, so start 63 with no payload is good
        send_frame(63, 0, 1'b0);
    endtask

    // Backpressure: hold the result side long enough that the parser stalls its
    // input, then drain and push the longest frame through.
    task automatic test_backpressure();
        apply_settings(8'($urandom), 8'($urandom), 8'd64, 8'd48);
        hold_req = 300;
        send_frame(5, 2, 1'b0);
        send_frame(0, 3, 1'b0);
        send_frame(20, 4, 1'b1);
        send_frame(40, 1, 1'b0);
        pause_until_drained();
        send_frame(0, PAYLOAD_DEPTH - 1, 1'b0);
        pause_until_drained();
    endtask

    // Random traffic across several register settings
    task automatic test_random_settings();
        apply_settings(8'($urandom), 8'($urandom), 8'd64, 8'd48);
        run_traffic(30);
        apply_settings(8'hFF, 8'h00, 8'h7F, 8'd1);
        run_traffic(20);
        apply_settings(8'h00, 8'hFF, 8'd1, 8'd255);
        run_traffic(15);
        apply_settings(8'($urandom), 8'($urandom), 8'($urandom_range(2, 63)),
                       8'($urandom_range(2, 30)));
        run_traffic(25);
    endtask

    // Full-rate tail: no idling on either side
    task automatic test_full_rate();
        apply_settings(8'($urandom), 8'($urandom), 8'd64, 8'($urandom_range(8, 60)));
        sender_gaps = 1'b0;
        sink_gaps   = 1'b0;
        run_traffic(25);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        wr_en               = 1'b0;
        wr_index            = CFG_DEVICE_ADDRESS;
        wr_data             = '0;
        rx_link.valid       = 1'b0;
        rx_link.rx_byte     = '0;
        result_link.ready   = 1'b0;

        cfg_address = RESET_ADDRESS;
        cfg_opcode  = RESET_OPCODE;
        cfg_limit   = RESET_LIMIT;
        cfg_budget  = RESET_BUDGET;
        fail_tally  = '0;
        clear_frame();

        bytes_sent      = 0;
        results_checked = 0;
        mismatches      = 0;
        frames_good     = 0;
        header_rejects  = 0;
        checksum_errors = 0;
        budget_fails    = 0;
        hold_req        = 0;
        hold_left       = 0;
        stall_left      = 0;
        idle_cycles     = 0;
        sender_gaps     = 1'b1;
        sink_gaps       = 1'b1;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_header_checks();
        test_register_extremes();
        test_backpressure();
        test_random_settings();
        test_full_rate();

        // Drain, then idle for TAIL_CYCLES so any stray result can show
        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d link bytes and %0d result transfers, %0d good frames",
                 bytes_sent, results_checked, frames_good);
        $display("Discards: %0d header, %0d checksum, %0d budget fails; %0d mismatches",
                 header_rejects, checksum_errors, budget_fails, mismatches);
        if (mismatches == 0 && parser_results_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
